// ----- sv/mstw_pkg.sv -----
// Shared constants and types for the multi-slot task watchdog.
// Used by multi_slot_task_watchdog_top; depends on nothing else.
package mstw_pkg;

    // Table geometry
    localparam int SLOTS       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ACT_W       = $clog2(SLOTS + 1);
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    localparam logic [31:0] CHECK_INTERVAL_RST = 32'd1000;

    // Command modes
    localparam logic [3:0] MODE_REGISTER   = 4'd0;
    localparam logic [3:0] MODE_UNREGISTER = 4'd1;
    localparam logic [3:0] MODE_FEED       = 4'd2;
    localparam logic [3:0] MODE_ENABLE     = 4'd3;
    localparam logic [3:0] MODE_DISABLE    = 4'd4;
    localparam logic [3:0] MODE_TICK       = 4'd5;
    localparam logic [3:0] MODE_STATS      = 4'd6;
    localparam logic [3:0] MODE_START      = 4'd7;
    localparam logic [3:0] MODE_STOP       = 4'd8;

    // Result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVAL   = 2'd1;
    localparam logic [1:0] STAT_NOSPACE = 2'd2;
    localparam logic [1:0] STAT_NOENT   = 2'd3;

    // Slot states
    localparam logic [1:0] SLOT_INACTIVE = 2'd0;
    localparam logic [1:0] SLOT_ACTIVE   = 2'd1;
    localparam logic [1:0] SLOT_TIMEDOUT = 2'd2;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  slot_out;
        logic        timed_out;
        logic [63:0] timeout_total;
        logic [6:0]  active_count;
        logic        last;
    } result_t;

endpackage

// ----- sv/multi_slot_task_watchdog_top.sv -----
// Multi-slot task watchdog: slot table, tick counter and periodic timeout scan.
// Depends on mstw_pkg. Limits and feed times live in two registered-read memories;
// slot state and enable bits are flip-flops cleared by reset.
//
// Usage: commands arrive as beats on s_ (mode, slot, timeout). Every command
// gives at least one result beat on m_, with m_tlast marking the final beat of
// that command. A tick that triggers a scan gives one beat per timed-out slot
// (or a single ok beat when none timed out).
// A plain command's result is registered when the command is accepted and is
// valid in the next cycle; the next command may be accepted in the following
// cycle while m_tready keeps the output free. A scan walks the table one slot
// at a time, a memory read state and then a compare state for each slot.
// Start walks the table at one slot per cycle to refresh feed times; no command
// is taken during the walk.
// The user writes check_interval via cfg_we/cfg_wdata only when idle; unchecked.
// Reset (aresetn low, synchronous) clears all slots to inactive and disabled,
// time and interval counters, the running flag and the timeout tally, and
// loads check_interval with 1000. Limit and feed memories are not cleared.
// When the receiver stalls m_tready, the result register holds its beat,
// s_tready drops and any scan in progress waits before its next result.
module multi_slot_task_watchdog_top (
    input  logic        aclk,
    input  logic        aresetn,
    // mode[3:0], slot[9:4], timeout[41:10], zero fill[47:42]
    input  logic [47:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // status[1:0], slot_out[7:2], timed_out[8], timeout_total[72:9],
    // active_count[79:73]
    output logic [79:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN_RD  = 3'd1;
    localparam logic [2:0] ST_SCAN_EV  = 3'd2;
    localparam logic [2:0] ST_SCAN_END = 3'd3;
    localparam logic [2:0] ST_START    = 3'd4;

    localparam logic [mstw_pkg::SLOT_W-1:0] LAST_IDX = mstw_pkg::SLOT_W'(mstw_pkg::SLOTS - 1);

    // Control registers
    logic [2:0]                    state_reg, state_next;
    logic [1:0]                    stat_reg [mstw_pkg::SLOTS];
    logic [1:0]                    stat_next [mstw_pkg::SLOTS];
    logic [mstw_pkg::SLOTS-1:0]    en_reg, en_next;
    logic [31:0]                   time_reg, time_next;
    logic [31:0]                   ivl_reg, ivl_next;
    logic                          run_reg, run_next;
    logic [63:0]                   tally_reg, tally_next;
    logic [31:0]                   check_interval_reg;
    logic [mstw_pkg::SLOT_W-1:0]   idx_reg, idx_next;
    logic [mstw_pkg::NRES_W-1:0]   nres_reg, nres_next;
    logic                          pend_reg, pend_next;
    logic [mstw_pkg::SLOT_W-1:0]   pend_slot_reg, pend_slot_next;
    logic                          m_tvalid_reg;
    mstw_pkg::result_t             out_reg, out_next;
    logic                          out_load;

    // Memories
    logic [31:0]                   lim_mem [mstw_pkg::SLOTS];
    logic [31:0]                   fed_mem [mstw_pkg::SLOTS];
    logic [31:0]                   lim_q, fed_q;
    logic                          lim_we, fed_we;
    logic [mstw_pkg::SLOT_W-1:0]   lim_waddr, fed_waddr;
    logic [31:0]                   lim_wdata, fed_wdata;

    // Input fields
    logic [3:0]                    in_mode;
    logic [5:0]                    in_slot;
    logic [31:0]                   in_tmo;
    logic [mstw_pkg::SLOT_W-1:0]   sidx;
    logic                          acc;
    logic                          out_free;

    // Derived
    logic                          free_found;
    logic [mstw_pkg::SLOT_W-1:0]   free_idx;
    logic [mstw_pkg::ACT_W-1:0]    act_cnt;
    logic [31:0]                   ivl_inc;
    logic [31:0]                   elapsed;
    logic                          hit;
    logic                          scan_done;

    assign in_mode = s_tdata[3:0];
    assign in_slot = s_tdata[9:4];
    assign in_tmo  = s_tdata[41:10];
    assign sidx    = in_slot[mstw_pkg::SLOT_W-1:0];

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign acc      = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {out_reg.active_count, out_reg.timeout_total, out_reg.timed_out,
                       out_reg.slot_out, out_reg.status};

    // Lowest inactive slot: scan from the top so the lowest hit wins
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = mstw_pkg::SLOTS - 1; i >= 0; i--) begin
            if (stat_reg[i] == mstw_pkg::SLOT_INACTIVE) begin
                free_found = 1'b1;
                free_idx   = mstw_pkg::SLOT_W'(i);
            end
        end
    end

    always_comb begin
        act_cnt = '0;
        for (int i = 0; i < mstw_pkg::SLOTS; i++) begin
            act_cnt = act_cnt + mstw_pkg::ACT_W'((stat_reg[i] == mstw_pkg::SLOT_ACTIVE) && en_reg[i]);
        end
    end

    assign ivl_inc = ivl_reg + 32'd1;
    assign elapsed = time_reg - fed_q;
    assign hit     = (stat_reg[idx_reg] == mstw_pkg::SLOT_ACTIVE) && en_reg[idx_reg]
                     && (elapsed > lim_q);
    assign scan_done = (idx_reg == LAST_IDX)
                       || (hit && (nres_reg + 1'b1 == mstw_pkg::NRES_W'(mstw_pkg::MAX_RESULTS)));

    always_comb begin
        state_next     = state_reg;
        stat_next      = stat_reg;
        en_next        = en_reg;
        time_next      = time_reg;
        ivl_next       = ivl_reg;
        run_next       = run_reg;
        tally_next     = tally_reg;
        idx_next       = idx_reg;
        nres_next      = nres_reg;
        pend_next      = pend_reg;
        pend_slot_next = pend_slot_reg;
        out_load       = 1'b0;
        out_next       = '0;
        out_next.status = mstw_pkg::STAT_OK;
        out_next.last  = 1'b1;
        lim_we         = 1'b0;
        lim_waddr      = '0;
        lim_wdata      = in_tmo;
        fed_we         = 1'b0;
        fed_waddr      = '0;
        fed_wdata      = time_reg;

        case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    out_load = 1'b1;
                    case (in_mode)
                        mstw_pkg::MODE_REGISTER: begin
                            if (in_tmo == 32'd0) begin
                                out_next.status = mstw_pkg::STAT_INVAL;
                            end else if (!free_found) begin
                                out_next.status = mstw_pkg::STAT_NOSPACE;
                            end else begin
                                lim_we              = 1'b1;
                                lim_waddr           = free_idx;
                                fed_we              = 1'b1;
                                fed_waddr           = free_idx;
                                stat_next[free_idx] = mstw_pkg::SLOT_ACTIVE;
                                en_next[free_idx]   = 1'b1;
                                out_next.slot_out   = 6'(free_idx);
                            end
                        end
                        mstw_pkg::MODE_UNREGISTER, mstw_pkg::MODE_FEED,
                        mstw_pkg::MODE_ENABLE, mstw_pkg::MODE_DISABLE: begin
                            if (7'(in_slot) >= 7'(mstw_pkg::SLOTS)) begin
                                out_next.status = mstw_pkg::STAT_INVAL;
                            end else if (stat_reg[sidx] == mstw_pkg::SLOT_INACTIVE) begin
                                out_next.status = mstw_pkg::STAT_NOENT;
                            end else if (in_mode == mstw_pkg::MODE_UNREGISTER) begin
                                stat_next[sidx] = mstw_pkg::SLOT_INACTIVE;
                                en_next[sidx]   = 1'b0;
                            end else if (in_mode == mstw_pkg::MODE_FEED) begin
                                fed_we          = 1'b1;
                                fed_waddr       = sidx;
                                stat_next[sidx] = mstw_pkg::SLOT_ACTIVE;
                            end else if (in_mode == mstw_pkg::MODE_ENABLE) begin
                                fed_we        = 1'b1;
                                fed_waddr     = sidx;
                                en_next[sidx] = 1'b1;
                            end else begin
                                en_next[sidx] = 1'b0;
                            end
                        end
                        mstw_pkg::MODE_TICK: begin
                            time_next = time_reg + 32'd1;
                            if (run_reg) begin
                                if (ivl_inc >= check_interval_reg) begin
                                    // scan owns the result channel until it ends
                                    ivl_next   = '0;
                                    out_load   = 1'b0;
                                    idx_next   = '0;
                                    nres_next  = '0;
                                    state_next = ST_SCAN_RD;
                                end else begin
                                    ivl_next = ivl_inc;
                                end
                            end
                        end
                        mstw_pkg::MODE_STATS: begin
                            out_next.timeout_total = tally_reg;
                            out_next.active_count  = 7'(act_cnt);
                        end
                        mstw_pkg::MODE_START: begin
                            if (!run_reg) begin
                                run_next   = 1'b1;
                                ivl_next   = '0;
                                idx_next   = '0;
                                state_next = ST_START;
                            end
                        end
                        mstw_pkg::MODE_STOP: begin
                            run_next = 1'b0;
                        end
                        default: begin
                            out_next.status = mstw_pkg::STAT_INVAL;
                        end
                    endcase
                end
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_EV;
            end
            ST_SCAN_EV: begin
                // hold the slot while an earlier timeout still waits for the output
                if (!(hit && pend_reg && !out_free)) begin
                    if (hit) begin
                        stat_next[idx_reg] = mstw_pkg::SLOT_TIMEDOUT;
                        tally_next         = tally_reg + 64'd1;
                        nres_next          = nres_reg + 1'b1;
                        pend_next          = 1'b1;
                        pend_slot_next     = idx_reg;
                        if (pend_reg) begin
                            out_load           = 1'b1;
                            out_next.slot_out  = 6'(pend_slot_reg);
                            out_next.timed_out = 1'b1;
                            out_next.last      = 1'b0;
                        end
                    end
                    if (scan_done) begin
                        state_next = ST_SCAN_END;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_END: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (pend_reg) begin
                        out_next.slot_out  = 6'(pend_slot_reg);
                        out_next.timed_out = 1'b1;
                    end
                    pend_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            ST_START: begin
                if (stat_reg[idx_reg] == mstw_pkg::SLOT_ACTIVE) begin
                    fed_we    = 1'b1;
                    fed_waddr = idx_reg;
                end
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            en_reg             <= '0;
            time_reg           <= '0;
            ivl_reg            <= '0;
            run_reg            <= 1'b0;
            tally_reg          <= '0;
            idx_reg            <= '0;
            nres_reg           <= '0;
            pend_reg           <= 1'b0;
            m_tvalid_reg       <= 1'b0;
            check_interval_reg <= mstw_pkg::CHECK_INTERVAL_RST;
            for (int i = 0; i < mstw_pkg::SLOTS; i++) begin
                stat_reg[i] <= mstw_pkg::SLOT_INACTIVE;
            end
        end else begin
            state_reg <= state_next;
            stat_reg  <= stat_next;
            en_reg    <= en_next;
            time_reg  <= time_next;
            ivl_reg   <= ivl_next;
            run_reg   <= run_next;
            tally_reg <= tally_next;
            idx_reg   <= idx_next;
            nres_reg  <= nres_next;
            pend_reg  <= pend_next;
            if (cfg_we) begin
                check_interval_reg <= cfg_wdata;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pend_slot_reg <= pend_slot_next;
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    // Limit and feed-time memories, read data registered
    always_ff @(posedge aclk) begin
        if (lim_we) begin
            lim_mem[lim_waddr] <= lim_wdata;
        end
        if (fed_we) begin
            fed_mem[fed_waddr] <= fed_wdata;
        end
        lim_q <= lim_mem[idx_reg];
        fed_q <= fed_mem[idx_reg];
    end

    // A timeout beat leaves only from the pending holder
    a_timeout_from_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_next.timed_out) |-> pend_reg)
        else $error("timeout beat without pending slot");

    // The tally moves only while a slot is being evaluated
    a_tally_only_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_SCAN_EV) |=> $stable(tally_reg))
        else $error("timeout tally changed outside a scan");

    // No timeout is left pending once the block is back to taking commands
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_reg)
        else $error("pending timeout while idle");

endmodule

// ----- bench/multi_slot_task_watchdog_top_test.sv -----
// Self-checking bench for multi_slot_task_watchdog_top: commands go in as beats on s_,
// and every result beat on m_ is checked against a watchdog table kept in this file.
// Depends on mstw_pkg (sv/mstw_pkg.sv) and the RTL under sv/.
module multi_slot_task_watchdog_top_test;

    localparam int HALF_PERIOD  = 2;
    localparam int SETTLE       = 2 * mstw_pkg::SLOTS + 8;  // longest scan plus margin
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 400000;

    logic        aclk;
    logic        aresetn;
    logic [47:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic        m_tlast;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    multi_slot_task_watchdog_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // Watchdog table as the bench sees it
    logic [1:0]  wd_state   [mstw_pkg::SLOTS];
    logic        wd_en      [mstw_pkg::SLOTS];
    logic [31:0] wd_limit   [mstw_pkg::SLOTS];
    logic [31:0] wd_fed     [mstw_pkg::SLOTS];
    logic [31:0] now_ticks;
    logic [31:0] ticks_since_scan;
    logic [31:0] scan_interval;
    logic        wd_running;
    logic [63:0] timeouts_seen;

    mstw_pkg::result_t pending_results[$];
    int      mismatches;
    int      cycle_count;
    int      hold_left;
    int      rx_gap_left;
    bit      tx_idle_on;
    bit      rx_idle_on;

    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Apply one accepted command to the table and queue the beats it must produce.
    task automatic predict_command(input logic [3:0] mode, input logic [5:0] slot,
                                   input logic [31:0] tmo);
        mstw_pkg::result_t           r;
        mstw_pkg::result_t           hit;
        int                          free_slot;
        int                          hit_slots[$];
        logic [31:0]                 elapsed;
        logic [6:0]                  enabled_active;
        logic [mstw_pkg::SLOT_W-1:0] si;
        r = '0;
        free_slot = -1;
        enabled_active = '0;
        si = slot[mstw_pkg::SLOT_W-1:0];
        if (mode >= mstw_pkg::MODE_UNREGISTER && mode <= mstw_pkg::MODE_DISABLE) begin
            if (slot >= mstw_pkg::SLOTS) begin
                r.status = mstw_pkg::STAT_INVAL;
            end else if (wd_state[si] == mstw_pkg::SLOT_INACTIVE) begin
                r.status = mstw_pkg::STAT_NOENT;
            end else if (mode == mstw_pkg::MODE_UNREGISTER) begin
                wd_state[si] = mstw_pkg::SLOT_INACTIVE;
                wd_en[si] = 1'b0;
            end else if (mode == mstw_pkg::MODE_FEED) begin
                wd_fed[si] = now_ticks;
                wd_state[si] = mstw_pkg::SLOT_ACTIVE;
            end else if (mode == mstw_pkg::MODE_ENABLE) begin
                wd_en[si] = 1'b1;
                wd_fed[si] = now_ticks;
            end else begin
                wd_en[si] = 1'b0;
            end
        end else if (mode == mstw_pkg::MODE_REGISTER) begin
            if (tmo == 32'd0) begin
                r.status = mstw_pkg::STAT_INVAL;
            end else begin
                for (int i = mstw_pkg::SLOTS - 1; i >= 0; i--)
                    if (wd_state[i] == mstw_pkg::SLOT_INACTIVE)
                        free_slot = i;
                if (free_slot < 0) begin
                    r.status = mstw_pkg::STAT_NOSPACE;
                end else begin
                    wd_limit[free_slot] = tmo;
                    wd_fed[free_slot] = now_ticks;
                    wd_state[free_slot] = mstw_pkg::SLOT_ACTIVE;
                    wd_en[free_slot] = 1'b1;
                    r.slot_out = 6'(free_slot);
                end
            end
        end else if (mode == mstw_pkg::MODE_TICK) begin
            now_ticks = now_ticks + 32'd1;
            if (wd_running) begin
                ticks_since_scan = ticks_since_scan + 32'd1;
                if (ticks_since_scan >= scan_interval) begin
                    ticks_since_scan = '0;
                    for (int i = 0; i < mstw_pkg::SLOTS; i++) begin
                        elapsed = now_ticks - wd_fed[i];
                        if (hit_slots.size() < mstw_pkg::MAX_RESULTS &&
                            wd_state[i] == mstw_pkg::SLOT_ACTIVE &&
                            wd_en[i] && elapsed > wd_limit[i]) begin
                            wd_state[i] = mstw_pkg::SLOT_TIMEDOUT;
                            timeouts_seen = timeouts_seen + 64'd1;
                            hit_slots.push_back(i);
                        end
                    end
                end
            end
        end else if (mode == mstw_pkg::MODE_STATS) begin
            for (int i = 0; i < mstw_pkg::SLOTS; i++)
                if (wd_state[i] == mstw_pkg::SLOT_ACTIVE && wd_en[i])
                    enabled_active = enabled_active + 7'd1;
            r.timeout_total = timeouts_seen;
            r.active_count = enabled_active;
        end else if (mode == mstw_pkg::MODE_START) begin
            if (!wd_running) begin
                wd_running = 1'b1;
                ticks_since_scan = '0;
                for (int i = 0; i < mstw_pkg::SLOTS; i++)
                    if (wd_state[i] == mstw_pkg::SLOT_ACTIVE)
                        wd_fed[i] = now_ticks;
            end
        end else if (mode == mstw_pkg::MODE_STOP) begin
            wd_running = 1'b0;
        end else begin
            r.status = mstw_pkg::STAT_INVAL;
        end

        if (hit_slots.size() == 0) begin
            r.last = 1'b1;
            pending_results.push_back(r);
        end else begin
            foreach (hit_slots[k]) begin
                hit = '0;
                hit.status = mstw_pkg::STAT_OK;
                hit.slot_out = 6'(hit_slots[k]);
                hit.timed_out = 1'b1;
                hit.last = (k == hit_slots.size() - 1);
                pending_results.push_back(hit);
            end
        end
    endtask

    // Offer one command beat, hold it until taken, then predict its results.
    task automatic send_cmd(input logic [3:0] mode, input logic [5:0] slot,
                            input logic [31:0] tmo);
        int gap;
        gap = (tx_idle_on && $urandom_range(0, 1) == 1) ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {6'd0, tmo, slot, mode};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_command(mode, slot, tmo);
    endtask

    // Mostly legal traffic on in-range slots, with some out-of-range slots and junk modes.
    task automatic send_random_cmd();
        int          pick;
        logic [3:0]  mode;
        logic [5:0]  slot;
        logic [31:0] tmo;
        pick = $urandom_range(0, 99);
        slot = 6'($urandom_range(0, 63));
        tmo = $urandom;
        if ($urandom_range(0, 99) < 85)
            slot = 6'($urandom_range(0, mstw_pkg::SLOTS - 1));
        if (pick < 20) begin
            mode = mstw_pkg::MODE_REGISTER;
            pick = $urandom_range(0, 9);
            if (pick == 0)
                tmo = '0;
            else if (pick > 2)
                tmo = $urandom_range(1, 12);
        end else if (pick < 45) mode = mstw_pkg::MODE_TICK;
        else if (pick < 55) mode = mstw_pkg::MODE_FEED;
        else if (pick < 62) mode = mstw_pkg::MODE_ENABLE;
        else if (pick < 68) mode = mstw_pkg::MODE_DISABLE;
        else if (pick < 74) mode = mstw_pkg::MODE_UNREGISTER;
        else if (pick < 82) mode = mstw_pkg::MODE_STATS;
        else if (pick < 87) mode = mstw_pkg::MODE_START;
        else if (pick < 91) mode = mstw_pkg::MODE_STOP;
        else mode = 4'($urandom_range(9, 15));
        send_cmd(mode, slot, tmo);
    endtask

    // Drop valid, wait for every expected beat, then let any trailing scan finish.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_interval(input logic [31:0] value);
        wait_idle();
        cfg_wdata <= value;
        cfg_we <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        scan_interval = value;
    endtask

    task automatic test_directed();
        send_cmd(mstw_pkg::MODE_STATS, 6'd0, 32'd0);
        write_interval(32'd1);
        send_cmd(mstw_pkg::MODE_REGISTER, 6'd0, 32'd0);
        send_cmd(mstw_pkg::MODE_REGISTER, 6'd0, 32'd1);
        send_cmd(mstw_pkg::MODE_REGISTER, 6'd63, 32'hFFFF_FFFF);
        send_cmd(mstw_pkg::MODE_REGISTER, 6'd0, 32'd2);
        send_cmd(4'd9, 6'd0, 32'd0);
        send_cmd(4'd15, 6'd63, 32'hFFFF_FFFF);
        send_cmd(mstw_pkg::MODE_UNREGISTER, 6'd63, 32'd0);
        send_cmd(mstw_pkg::MODE_FEED, 6'(mstw_pkg::SLOTS), 32'd0);
        send_cmd(mstw_pkg::MODE_ENABLE, 6'd5, 32'd0);
        send_cmd(mstw_pkg::MODE_DISABLE, 6'd5, 32'd0);
        send_cmd(mstw_pkg::MODE_START, 6'd0, 32'd0);
        send_cmd(mstw_pkg::MODE_START, 6'd0, 32'd0);
        // slot 0 and then slot 2 run past their limits
        repeat (3) send_cmd(mstw_pkg::MODE_TICK, 6'd0, 32'd0);
        send_cmd(mstw_pkg::MODE_FEED, 6'd0, 32'd0);
        send_cmd(mstw_pkg::MODE_ENABLE, 6'd2, 32'd0);
        send_cmd(mstw_pkg::MODE_DISABLE, 6'd1, 32'd0);
        send_cmd(mstw_pkg::MODE_STATS, 6'd0, 32'd0);
        send_cmd(mstw_pkg::MODE_UNREGISTER, 6'd0, 32'd0);
        send_cmd(mstw_pkg::MODE_STOP, 6'd0, 32'd0);
        send_cmd(mstw_pkg::MODE_STOP, 6'd0, 32'd0);
        send_cmd(mstw_pkg::MODE_TICK, 6'd0, 32'd0);
        send_cmd(mstw_pkg::MODE_STATS, 6'd0, 32'd0);
    endtask

    task automatic test_random_traffic(input logic [31:0] interval, input int count,
                                       input bit idling);
        write_interval(interval);
        tx_idle_on = idling;
        rx_idle_on <= idling;
        repeat (count) send_random_cmd();
        tx_idle_on = 1'b1;
        rx_idle_on <= 1'b1;
    endtask

    // Fill the whole table with short limits so one scan reports every slot.
    task automatic test_full_table();
        write_interval(32'd5);
        for (int i = 0; i < mstw_pkg::SLOTS; i++)
            send_cmd(mstw_pkg::MODE_UNREGISTER, 6'(i), $urandom);
        repeat (mstw_pkg::SLOTS + 1) send_cmd(mstw_pkg::MODE_REGISTER,
                                              6'($urandom_range(0, 63)),
                                              $urandom_range(1, 4));
        send_cmd(mstw_pkg::MODE_STOP, 6'd0, 32'd0);
        send_cmd(mstw_pkg::MODE_START, 6'd0, 32'd0);
        repeat (6) send_cmd(mstw_pkg::MODE_TICK, 6'($urandom_range(0, 63)), $urandom);
        send_cmd(mstw_pkg::MODE_STATS, 6'd0, 32'd0);
    endtask

    // Receiver holds off while commands keep coming, so the block backs up.
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        hold_left <= LONG_HOLD;
        repeat (10) send_random_cmd();
        wait_idle();
        tx_idle_on = 1'b1;
    endtask

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (rx_gap_left > 0) begin
            m_tready <= 1'b0;
            rx_gap_left <= rx_gap_left - 1;
        end else begin
            m_tready <= 1'b1;
            if (rx_idle_on && $urandom_range(0, 99) < 25)
                rx_gap_left <= pick_gap();
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        mstw_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual tdata %h last %b",
                         $time, m_tdata, m_tlast);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 64'(want.status), 64'(m_tdata[1:0]));
                check_field("slot_out", 64'(want.slot_out), 64'(m_tdata[7:2]));
                check_field("timed_out", 64'(want.timed_out), 64'(m_tdata[8]));
                check_field("timeout_total", want.timeout_total, m_tdata[72:9]);
                check_field("active_count", 64'(want.active_count), 64'(m_tdata[79:73]));
                check_field("last", 64'(want.last), 64'(m_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("multi_slot_task_watchdog_top_test NOT OK");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tdata = '0;
        s_tvalid = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        mismatches = 0;
        cycle_count = 0;
        hold_left = 0;
        rx_gap_left = 0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (int i = 0; i < mstw_pkg::SLOTS; i++) begin
            wd_state[i] = mstw_pkg::SLOT_INACTIVE;
            wd_en[i] = 1'b0;
            wd_limit[i] = '0;
            wd_fed[i] = '0;
        end
        now_ticks = '0;
        ticks_since_scan = '0;
        scan_interval = mstw_pkg::CHECK_INTERVAL_RST;
        wd_running = 1'b0;
        timeouts_seen = '0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_traffic(32'd3, 12, 1'b1);
        test_random_traffic(32'd0, 8, 1'b0);
        test_full_table();
        test_backpressure();
        test_random_traffic(32'hFFFF_FFFF, 6, 1'b1);
        test_random_traffic(32'd2, 8, 1'b1);

        wait_idle();
        if (mismatches == 0)
            $display("multi_slot_task_watchdog_top_test OK");
        else
            $display("multi_slot_task_watchdog_top_test NOT OK");
        $finish;
    end

endmodule
